[design/enc8b_pkg.sv]
// Shared types, code tables and constants for the 8b/10b biphase line encoder.
package enc8b_pkg;

    localparam int CODE_W = 10;
    localparam int HALF_W = 2 * CODE_W;

    // Configuration register indexes.
    localparam logic REG_COMMA_NEG = 1'b0;
    localparam logic REG_COMMA_POS = 1'b1;

    // Reset values of the comma registers.
    localparam logic [CODE_W-1:0] COMMA_NEG_RESET = 10'd250;
    localparam logic [CODE_W-1:0] COMMA_POS_RESET = 10'd773;

    // Function code of an input item.
    localparam logic FUNC_DATA  = 1'b0;
    localparam logic FUNC_COMMA = 1'b1;

    // Input item: a data byte or a comma request.
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_in_item;

    // Result item: ten-bit symbol, its line half-bits and the new disparity.
    typedef struct packed {
        logic [CODE_W-1:0] code_word;
        logic [HALF_W-1:0] half_bits;
        logic              disparity_positive;
    } t_out_item;

    // 5b/6b codes, already placed in bits 9..4, for negative running disparity.
    localparam logic [CODE_W-1:0] SIX_NEG [0:31] = '{
        10'h270, 10'h1D0, 10'h2D0, 10'h310, 10'h350, 10'h290, 10'h190, 10'h380,
        10'h390, 10'h250, 10'h150, 10'h340, 10'h0D0, 10'h2C0, 10'h1C0, 10'h170,
        10'h1B0, 10'h230, 10'h130, 10'h320, 10'h0B0, 10'h2A0, 10'h1A0, 10'h3A0,
        10'h330, 10'h260, 10'h160, 10'h360, 10'h0E0, 10'h2E0, 10'h1E0, 10'h2B0
    };

    // 5b/6b codes for positive running disparity.
    localparam logic [CODE_W-1:0] SIX_POS [0:31] = '{
        10'h180, 10'h220, 10'h120, 10'h310, 10'h0A0, 10'h290, 10'h190, 10'h070,
        10'h060, 10'h250, 10'h150, 10'h340, 10'h0D0, 10'h2C0, 10'h1C0, 10'h280,
        10'h240, 10'h230, 10'h130, 10'h320, 10'h0B0, 10'h2A0, 10'h1A0, 10'h050,
        10'h0C0, 10'h260, 10'h160, 10'h090, 10'h0E0, 10'h110, 10'h210, 10'h140
    };

    // One bit per 5b value: set where the six-bit code is unbalanced.
    localparam logic [31:0] SIX_FLIP = 32'hE981_8117;

    // 3b/4b codes by running disparity, x.7 included.
    localparam logic [3:0] FOUR_NEG [0:7] = '{
        4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
    };
    localparam logic [3:0] FOUR_POS [0:7] = '{
        4'h4, 4'h9, 4'h5, 4'h3, 4'h2, 4'hA, 4'h6, 4'h1
    };

    // One bit per 3b value: set where the four-bit code is unbalanced.
    localparam logic [7:0] FOUR_FLIP = 8'h91;

endpackage

[design/enc8b_symbol.sv]
// Table lookup of one ten-bit symbol and the running disparity that follows it.
module enc8b_symbol (
    input  enc8b_pkg::t_in_item                i_item,
    input  logic                               i_rd_positive,
    input  logic [enc8b_pkg::CODE_W-1:0]       i_comma_neg,
    input  logic [enc8b_pkg::CODE_W-1:0]       i_comma_pos,
    output logic [enc8b_pkg::CODE_W-1:0]       o_code,
    output logic                               o_rd_positive
);
    import enc8b_pkg::*;

    logic [4:0]        lo;
    logic [2:0]        hi;
    logic [CODE_W-1:0] six_code;
    logic              rd_mid;
    logic [3:0]        four_code;
    logic              rd_data;

    // Split the byte into its 5b and 3b parts.
    assign lo = i_item.data_byte[4:0];
    assign hi = i_item.data_byte[7:5];

    // The 6b part picks by the current disparity, the 4b part by the one after it.
    assign six_code  = i_rd_positive ? SIX_POS[lo] : SIX_NEG[lo];
    assign rd_mid    = i_rd_positive ^ SIX_FLIP[lo];
    assign four_code = rd_mid ? FOUR_POS[hi] : FOUR_NEG[hi];
    assign rd_data   = rd_mid ^ FOUR_FLIP[hi];

    // A comma sends the configured symbol and always flips the disparity.
    always_comb begin
        if (i_item.func == FUNC_COMMA) begin
            o_code        = i_rd_positive ? i_comma_pos : i_comma_neg;
            o_rd_positive = ~i_rd_positive;
        end else begin
            o_code        = six_code | {6'd0, four_code};
            o_rd_positive = rd_data;
        end
    end

endmodule

[design/enc8b_biphase.sv]
// Biphase-mark expansion of a ten-bit symbol into twenty line half-bits.
module enc8b_biphase (
    input  logic [enc8b_pkg::CODE_W-1:0] i_code,
    input  logic                         i_level,
    output logic [enc8b_pkg::HALF_W-1:0] o_half_bits,
    output logic                         o_level
);
    import enc8b_pkg::*;

    // The level at the start of bit k is the start level, toggled once per
    // earlier bit boundary and once per earlier one bit, so each bit is
    // found from a prefix parity on its own.
    always_comb begin
        logic [CODE_W-1:0] mask;
        logic              lv;
        o_half_bits = '0;
        for (int k = 0; k < CODE_W; k++) begin
            mask                 = (CODE_W'(1) << k) - CODE_W'(1);
            lv                   = i_level ^ (^(i_code & mask)) ^ k[0];
            o_half_bits[2*k]     = lv;
            o_half_bits[2*k + 1] = lv ^ i_code[k];
        end
    end

    // Level of the first half-bit of the next symbol.
    assign o_level = i_level ^ (^i_code) ^ CODE_W[0];

endmodule

[design/enc8b10b_biphase_line_encoder.sv]
// Top level of the 8b/10b encoder with biphase-mark line expansion.
// An accepted item is held in the input register until the result register
// is free or being taken; its result is then registered there.
// Throughput: one item per cycle unless the output stalls; the disparity
// and line-level update of one item is a single pass of table lookup and
// ten-bit expansion. Reset (synchronous, active low) empties both stages,
// sets negative disparity, a high line level and the default comma symbols.
module enc8b10b_biphase_line_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  enc8b_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output enc8b_pkg::t_out_item          o_out_item,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [enc8b_pkg::CODE_W-1:0]  i_cfg_data
);
    import enc8b_pkg::*;

    logic              r_in_valid;
    t_in_item          r_in_item;
    logic              r_out_valid;
    t_out_item         r_out_item;
    logic              r_rd_positive;
    logic              r_level;
    logic [CODE_W-1:0] r_comma_neg;
    logic [CODE_W-1:0] r_comma_pos;

    logic              advance;
    logic [CODE_W-1:0] code;
    logic              n_rd_positive;
    logic [HALF_W-1:0] half_bits;
    logic              n_level;

    // The held item moves on when the result register is free or being taken.
    assign advance     = ~r_out_valid | ~i_out_stall;
    assign o_in_stall  = r_in_valid & ~advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comma_neg <= COMMA_NEG_RESET;
            r_comma_pos <= COMMA_POS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COMMA_NEG: r_comma_neg <= i_cfg_data;
                REG_COMMA_POS: r_comma_pos <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Symbol lookup and disparity update.
    enc8b_symbol u_symbol (
        .i_item        (r_in_item),
        .i_rd_positive (r_rd_positive),
        .i_comma_neg   (r_comma_neg),
        .i_comma_pos   (r_comma_pos),
        .o_code        (code),
        .o_rd_positive (n_rd_positive)
    );

    // Line expansion.
    enc8b_biphase u_biphase (
        .i_code      (code),
        .i_level     (r_level),
        .o_half_bits (half_bits),
        .o_level     (n_level)
    );

    // Encoder state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_rd_positive <= 1'b0;
            r_level       <= 1'b1;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_rd_positive <= n_rd_positive;
                r_level       <= n_level;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_item.code_word          <= code;
            r_out_item.half_bits          <= half_bits;
            r_out_item.disparity_positive <= n_rd_positive;
        end
    end

endmodule
